### hw/rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg: shared types and constants of the button debounce core
// Holds the state and result records passed between the core and its
// per-poll update logic, plus the configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 2'd1;

    // Reset values of the configuration registers, in milliseconds.
    localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] long_press_time;
    } bdpc_cfg_t;

    typedef struct packed {
        logic              edge_pending;
        logic [TIME_W-1:0] edge_stamp;
        logic              stable_level;
        logic [TIME_W-1:0] press_stamp;
        logic              short_flag;
        logic              long_flag;
        logic              long_done;
    } bdpc_state_t;

    typedef struct packed {
        logic pressed;
        logic short_press;
        logic long_press;
    } bdpc_result_t;

endpackage

`default_nettype wire

### hw/rtl/bdpc_update.sv
// ----------------------------------------------------------------------------
// bdpc_update: next-state logic for one button poll
// Applies the edge report, the debounce check and the long press check to
// the current state and forms the result seen before acknowledges apply.
// ----------------------------------------------------------------------------
`default_nettype none

module bdpc_update (
    input  wire bdpc_pkg::bdpc_state_t        state_cur,
    input  wire bdpc_pkg::bdpc_cfg_t          cfg,
    input  wire [bdpc_pkg::TIME_W-1:0]        now_ms,
    input  wire                               pin_level,
    input  wire                               change_seen,
    input  wire                               ack_short,
    input  wire                               ack_long,
    output bdpc_pkg::bdpc_state_t             state_next,
    output bdpc_pkg::bdpc_result_t            result
);

    logic                        level_now;
    logic                        pending;
    logic [bdpc_pkg::TIME_W-1:0] edge_age;
    logic [bdpc_pkg::TIME_W-1:0] press_age;
    logic                        age_ok;
    logic                        sample;
    logic                        new_press;
    logic                        release_seen;
    logic                        stable_n;
    logic [bdpc_pkg::TIME_W-1:0] press_stamp_n;
    logic                        long_done_mid;
    logic                        hold_ok;
    logic                        fire;
    logic                        short_n;
    logic                        long_n;

    always_comb
    begin
        level_now = ~pin_level;
        pending   = change_seen | state_cur.edge_pending;

        // Both ages are formed in parallel; a fresh edge or a fresh press
        // has an age of zero.
        edge_age  = now_ms - state_cur.edge_stamp;
        press_age = now_ms - state_cur.press_stamp;

        if (change_seen)
        begin
            age_ok = (cfg.debounce_time == '0);
        end
        else
        begin
            age_ok = (edge_age >= {{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}},
                                   cfg.debounce_time});
        end

        sample       = pending & age_ok;
        new_press    = sample & level_now & ~state_cur.stable_level;
        release_seen = sample & ~level_now & state_cur.stable_level;
        stable_n     = sample ? level_now : state_cur.stable_level;

        press_stamp_n = new_press ? now_ms : state_cur.press_stamp;
        long_done_mid = new_press ? 1'b0 : state_cur.long_done;
        short_n       = state_cur.short_flag | (release_seen & ~state_cur.long_done);

        if (new_press)
        begin
            hold_ok = (cfg.long_press_time == '0);
        end
        else
        begin
            hold_ok = (press_age >= {{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}},
                                     cfg.long_press_time});
        end

        // A press stamp of zero never fires a long press.
        fire   = stable_n & ~long_done_mid & (press_stamp_n != '0) & hold_ok;
        long_n = state_cur.long_flag | fire;

        result.pressed     = stable_n;
        result.short_press = short_n;
        result.long_press  = long_n;

        state_next.edge_pending = pending & ~sample;
        state_next.edge_stamp   = change_seen ? now_ms : state_cur.edge_stamp;
        state_next.stable_level = stable_n;
        state_next.press_stamp  = press_stamp_n;
        state_next.short_flag   = short_n & ~ack_short;
        state_next.long_flag    = long_n & ~ack_long;
        state_next.long_done    = long_done_mid | fire;
    end

endmodule

`default_nettype wire

### hw/rtl/button_debounce_press_classifier_core.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_core: debounced button with press classes
// Debounces an active-low button from timestamped polls and reports the
// pressed state together with sticky short and long press flags.
// ----------------------------------------------------------------------------
// Each input transfer is one poll of the button at a millisecond timestamp.
// The core takes one poll per clock and returns exactly one result per poll,
// in order. A poll is captured in an input register; whenever the result
// register is free or is being emptied, the update logic (two 32-bit
// subtract-and-compare paths working in parallel) advances the button
// state and loads the result register, so the sustained rate is one poll
// per cycle while the output side keeps taking results. When
// the output stalls, one more poll is still taken into the input register.
// The short and long press flags are sticky: a result shows each flag before
// the acknowledge bits of the same poll clear it. A press that debounces at
// timestamp zero never reports a long press. Configuration registers
// (debounce_time at index 0, long_press_time at index 1, both in ms) are
// written through the configuration channel, which is always ready; writes
// to other indexes are ignored. Write them only while no poll is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_classifier_core (
    input  wire                                clk,
    input  wire                                rst_n,

    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire [bdpc_pkg::TIME_W-1:0]         now_ms,
    input  wire                                pin_level,
    input  wire                                change_seen,
    input  wire                                ack_short,
    input  wire                                ack_long,

    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               pressed,
    output logic                               short_press,
    output logic                               long_press,

    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [bdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [bdpc_pkg::CFG_W-1:0]          cfg_data
);

    // Input register: one captured poll.
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [bdpc_pkg::TIME_W-1:0] s1_now_reg;
    logic                        s1_pin_reg;
    logic                        s1_change_reg;
    logic                        s1_ack_short_reg;
    logic                        s1_ack_long_reg;

    // Button state and configuration.
    bdpc_pkg::bdpc_state_t       state_reg;
    bdpc_pkg::bdpc_state_t       state_next;
    bdpc_pkg::bdpc_cfg_t         cfg_reg;

    // Result register.
    logic                        out_valid_reg;
    logic                        out_valid_next;
    bdpc_pkg::bdpc_result_t      result_reg;
    bdpc_pkg::bdpc_result_t      result_next;

    logic                        in_xfer;
    logic                        step;

    // The captured poll moves on whenever the result register is free or
    // is being emptied in this cycle.
    assign step      = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~s1_valid_reg | step;
    assign in_xfer   = in_valid & in_ready;
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign pressed     = result_reg.pressed;
    assign short_press = result_reg.short_press;
    assign long_press  = result_reg.long_press;

    bdpc_update u_update (
        .state_cur   (state_reg),
        .cfg         (cfg_reg),
        .now_ms      (s1_now_reg),
        .pin_level   (s1_pin_reg),
        .change_seen (s1_change_reg),
        .ack_short   (s1_ack_short_reg),
        .ack_long    (s1_ack_long_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    always_comb
    begin
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            cfg_reg.debounce_time   <= bdpc_pkg::DEBOUNCE_TIME_RST;
            cfg_reg.long_press_time <= bdpc_pkg::LONG_PRESS_TIME_RST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                state_reg <= state_next;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    bdpc_pkg::CFG_DEBOUNCE_TIME:   cfg_reg.debounce_time   <= cfg_data;
                    bdpc_pkg::CFG_LONG_PRESS_TIME: cfg_reg.long_press_time <= cfg_data;
                    default:                       ;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_now_reg       <= now_ms;
            s1_pin_reg       <= pin_level;
            s1_change_reg    <= change_seen;
            s1_ack_short_reg <= ack_short;
            s1_ack_long_reg  <= ack_long;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    // The button state only moves when a poll is processed.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg))
        else $error("button state changed without a processed poll");

    // A held poll stays in the input register until it is processed.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !step |=> s1_valid_reg && $stable(s1_now_reg)
            && $stable(s1_change_reg))
        else $error("captured poll lost while waiting");

    // A long press can only be flagged while the button is pressed.
    a_long_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.long_flag) |-> state_reg.stable_level)
        else $error("long press flagged while released");

    // A short press is only flagged on a debounced release.
    a_short_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg.short_flag) |-> $fell(state_reg.stable_level))
        else $error("short press flagged without a release");

endmodule

`default_nettype wire

### sim/button_debounce_press_classifier_core_test.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_core_test: self-checking bench for the core
// Drives timestamped button polls through the valid/ready input channel and
// checks each result against a cycle-free prediction of the debounce state
// and the sticky short and long press flags. Both channels stall at random,
// and the timing registers are swept across several settings.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_core_test;

    import bdpc_pkg::*;

    // One poll as the bench builds it, field for field the input payload.
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              pin_level;
        logic              change_seen;
        logic              ack_short;
        logic              ack_long;
    } poll_t;

    // Indexes above the last real register must be ignored by the core.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_LONG_PRESS_TIME + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = {CFG_IDX_W{1'b1}};

    // Pin levels as seen on the raw, active-low button input.
    localparam logic PIN_DOWN = 1'b0;
    localparam logic PIN_UP   = 1'b1;

    // ------------------------------------------------------------------------
    // Flag checker: keeps its own copy of the button state and the timing
    // registers, predicts the result of every accepted poll, and compares
    // each result that leaves the core with the oldest prediction.
    // ------------------------------------------------------------------------
    class press_flag_checker;
        bdpc_cfg_t    timing;
        bdpc_state_t  button;
        bdpc_result_t expected_flags[$];
        int           failures;
        int           results_seen;

        function new();
            timing.debounce_time   = DEBOUNCE_TIME_RST;
            timing.long_press_time = LONG_PRESS_TIME_RST;
            button       = '0;
            failures     = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_DEBOUNCE_TIME:   timing.debounce_time   = data;
                CFG_LONG_PRESS_TIME: timing.long_press_time = data;
                default: ;
            endcase
        endfunction

        // Advance the button state by one poll and queue the result it gives.
        function void take_poll(poll_t p);
            logic              down_now;
            logic              was_down;
            logic [TIME_W-1:0] age;
            bdpc_result_t      flags;

            down_now = (p.pin_level == PIN_DOWN);
            if (p.change_seen)
            begin
                button.edge_pending = 1'b1;
                button.edge_stamp   = p.now_ms;
            end

            age = p.now_ms - button.edge_stamp;
            if (button.edge_pending && age >= TIME_W'(timing.debounce_time))
            begin
                was_down            = button.stable_level;
                button.stable_level = down_now;
                button.edge_pending = 1'b0;
                if (down_now && !was_down)
                begin
                    button.press_stamp = p.now_ms;
                    button.long_done   = 1'b0;
                end
                if (!down_now && was_down && !button.long_done)
                    button.short_flag = 1'b1;
            end

            // A press stamped at time zero never counts as a long press.
            age = p.now_ms - button.press_stamp;
            if (button.stable_level && !button.long_done && button.press_stamp != '0 &&
                age >= TIME_W'(timing.long_press_time))
            begin
                button.long_flag = 1'b1;
                button.long_done = 1'b1;
            end

            flags.pressed     = button.stable_level;
            flags.short_press = button.short_flag;
            flags.long_press  = button.long_flag;
            expected_flags.push_back(flags);

            if (p.ack_short)
                button.short_flag = 1'b0;
            if (p.ack_long)
                button.long_flag = 1'b0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_flags(bdpc_result_t got);
            bdpc_result_t want;

            if (expected_flags.size() == 0)
            begin
                note_failure($sformatf("unexpected result: pressed %0b short %0b long %0b",
                                       got.pressed, got.short_press, got.long_press));
                return;
            end
            want = expected_flags.pop_front();
            if (got.pressed !== want.pressed || got.short_press !== want.short_press ||
                got.long_press !== want.long_press)
                note_failure($sformatf(
                    "result %0d: expected pressed %0b short %0b long %0b, got %0b %0b %0b",
                    results_seen, want.pressed, want.short_press, want.long_press,
                    got.pressed, got.short_press, got.long_press));
            results_seen++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input has a known value from
    // time zero on.
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [TIME_W-1:0]    now_ms      = '0;
    logic                 pin_level   = PIN_UP;
    logic                 change_seen = 1'b0;
    logic                 ack_short   = 1'b0;
    logic                 ack_long    = 1'b0;

    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic                 pressed;
    logic                 short_press;
    logic                 long_press;

    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_DEBOUNCE_TIME;
    logic [CFG_W-1:0]     cfg_data    = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    button_debounce_press_classifier_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .now_ms      (now_ms),
        .pin_level   (pin_level),
        .change_seen (change_seen),
        .ack_short   (ack_short),
        .ack_long    (ack_long),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pressed     (pressed),
        .short_press (short_press),
        .long_press  (long_press),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    press_flag_checker scb = new();

    // Bench-side view of the button: the running poll time, the pin level
    // last driven, and the current timing registers used to shape stimulus.
    logic [TIME_W-1:0] poll_ms    = '0;
    logic              pin_now    = PIN_UP;
    int unsigned       db_ms      = 32'(DEBOUNCE_TIME_RST);
    int unsigned       lp_ms      = 32'(LONG_PRESS_TIME_RST);
    bit                quiet      = 1'b0;
    int                polls_sent = 0;
    int                stall_left = 0;

    // ------------------------------------------------------------------------
    // Result side. Results are sampled at the rising edge, before any of the
    // nonblocking updates of that edge land, so the sample is race free. The
    // ready line stalls at random: mostly short stalls, now and then a long
    // one, and no new stall starts while the bench runs a quiet stretch.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            scb.check_flags('{pressed: pressed, short_press: short_press,
                              long_press: long_press});
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (quiet || $urandom_range(0, 3) != 0)
            out_ready <= 1'b1;
        else
        begin
            stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 80)
                                                     : $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------

    // Idle cycles before the next poll: mostly none or a few, seldom many.
    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offers one poll and holds it until the transfer. Valid stays high into
    // the next poll when no gap follows, so it is never dropped and raised
    // again within one time step.
    task automatic send_poll(input poll_t p);
        int gap;

        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        now_ms      <= p.now_ms;
        pin_level   <= p.pin_level;
        change_seen <= p.change_seen;
        ack_short   <= p.ack_short;
        ack_long    <= p.ack_long;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        scb.take_poll(p);
        polls_sent++;
    endtask

    task automatic send_fields(input logic [TIME_W-1:0] ms, input logic pin,
                               input logic chg, input logic ack_s, input logic ack_l);
        send_poll('{now_ms: ms, pin_level: pin, change_seen: chg,
                    ack_short: ack_s, ack_long: ack_l});
    endtask

    // Moves the poll clock forward and sends a poll with random acknowledges.
    task automatic advance_poll(input int unsigned step, input logic pin, input logic chg);
        poll_ms = poll_ms + step;
        pin_now = pin;
        send_fields(poll_ms, pin, chg, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    endtask

    // Stops offering polls and waits until every expected result has come.
    // Each poll gives a result, so a short grace period covers the pipeline.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (scb.expected_flags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        scb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Reprograms both timing registers once the core has drained. Half the
    // time a write to an unused index is thrown in; it must change nothing.
    task automatic set_timing(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] hold);
        wait_idle();
        if ($urandom_range(0, 1) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                      CFG_W'($urandom()));
        write_reg(CFG_DEBOUNCE_TIME, debounce);
        write_reg(CFG_LONG_PRESS_TIME, hold);
        db_ms = 32'(debounce);
        lp_ms = 32'(hold);
    endtask

    // A few contact bounces, then the edge that settles on the given level.
    task automatic bounce_to(input logic level);
        int n;
        logic pin;

        n   = $urandom_range(0, 3);
        pin = level;
        repeat (n)
        begin
            pin = ~pin;
            advance_poll($urandom_range(0, db_ms / 4 + 1), pin, 1'b1);
        end
        advance_poll($urandom_range(0, db_ms / 4 + 1), level, 1'b1);
    endtask

    // Polls at the settled level until the last edge has aged past the
    // debounce time, sometimes landing exactly on the boundary.
    task automatic settle();
        int unsigned aged;
        int unsigned step;

        aged = 0;
        while (aged < db_ms)
        begin
            if ($urandom_range(0, 1) == 0)
                step = db_ms - aged;
            else
                step = $urandom_range(0, (db_ms - aged) / 2 + 1);
            aged += step;
            advance_poll(step, pin_now, 1'b0);
        end
    endtask

    // One well-formed press: bounce in, debounce, hold for a short or a long
    // time, bounce out, debounce. Now and then the press starts from a jump
    // in time so that the wrap of the millisecond counter and a press that
    // debounces at time zero both come up.
    task automatic press_cycle();
        int unsigned target;
        int unsigned held;
        int unsigned step;

        case ($urandom_range(0, 15))
            0: poll_ms = $urandom();
            1: poll_ms = '1 - $urandom_range(0, db_ms + lp_ms);
            2: poll_ms = '0 - TIME_W'(db_ms);
            default: ;
        endcase

        // At a jump to just before zero the press edge must land exactly on
        // the debounce boundary for the press to be stamped at time zero.
        bounce_to(PIN_DOWN);
        settle();

        if ($urandom_range(0, 1) == 0)
            target = $urandom_range(0, lp_ms);
        else
            target = lp_ms + $urandom_range(0, lp_ms / 4 + 3);
        held = 0;
        while (held < target)
        begin
            step = $urandom_range(1, lp_ms / 3 + 1);
            held += step;
            // A reported edge with no level change only clears the pending edge.
            advance_poll(step, PIN_DOWN, $urandom_range(0, 9) == 0);
        end

        bounce_to(PIN_UP);
        settle();
        repeat ($urandom_range(1, 2))
            advance_poll($urandom_range(0, lp_ms / 2 + 1), PIN_UP, 1'b0);
    endtask

    // Anything at all: random time, pin and edge, not tied to the running clock.
    task automatic noise_poll();
        poll_ms = $urandom();
        advance_poll(0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Short runs of edges and levels with no regard for debouncing.
    task automatic broken_sequence();
        repeat ($urandom_range(1, 6))
            advance_poll($urandom_range(0, db_ms + 2), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
    endtask

    // One random phase under one timing setting, with a full drain halfway.
    task automatic run_phase(input int budget);
        int  start;
        bit  drained;
        int  r;

        start   = polls_sent;
        drained = 1'b0;
        while (polls_sent - start < budget)
        begin
            if (!drained && polls_sent - start >= budget / 2)
            begin
                wait_idle();
                drained = 1'b1;
            end
            if ($urandom_range(0, 19) == 0)
                quiet = !quiet;
            r = $urandom_range(0, 9);
            if (r == 0)
                noise_poll();
            else if (r == 9)
                broken_sequence();
            else
                press_cycle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset timing: debounce 50 ms, long 1000 ms.
        // A press whose edge sits just below the wrap debounces at time zero,
        // so it is stamped zero and must not fire long however long it lasts.
        send_fields(32'hFFFF_FFCE, PIN_DOWN, 1'b1, 1'b0, 1'b0);
        send_fields(32'd0,         PIN_DOWN, 1'b0, 1'b0, 1'b0);
        send_fields(32'd2000,      PIN_DOWN, 1'b0, 1'b0, 1'b0);
        send_fields(32'd2001,      PIN_UP,   1'b1, 1'b0, 1'b0);
        // Release after the debounce time: the short flag sets, is shown
        // once more with its acknowledge, and then reads clear.
        send_fields(32'd2051,      PIN_UP,   1'b0, 1'b0, 1'b0);
        send_fields(32'd2052,      PIN_UP,   1'b0, 1'b1, 1'b0);
        send_fields(32'd2053,      PIN_UP,   1'b0, 1'b0, 1'b0);
        // A normal press held for exactly the long press time fires long;
        // the acknowledge in the same poll clears it afterwards.
        send_fields(32'd3000,      PIN_DOWN, 1'b1, 1'b0, 1'b0);
        send_fields(32'd3050,      PIN_DOWN, 1'b0, 1'b0, 1'b0);
        send_fields(32'd4050,      PIN_DOWN, 1'b0, 1'b0, 1'b1);
        // An edge with no level change is consumed and nothing else happens.
        send_fields(32'd4051,      PIN_DOWN, 1'b1, 1'b0, 1'b0);
        send_fields(32'd4101,      PIN_DOWN, 1'b0, 1'b0, 1'b0);
        // Release after a long fire leaves the short flag alone; acknowledges
        // of clear flags do nothing.
        send_fields(32'd4200,      PIN_UP,   1'b1, 1'b0, 1'b0);
        send_fields(32'd4250,      PIN_UP,   1'b0, 1'b0, 1'b0);
        send_fields(32'd4251,      PIN_UP,   1'b0, 1'b1, 1'b1);
        // Debounce across the wrap of the millisecond counter, one short of
        // the debounce time and then exactly on it.
        send_fields(32'hFFFF_FFFF, PIN_DOWN, 1'b1, 1'b0, 1'b0);
        send_fields(32'h0000_0030, PIN_DOWN, 1'b0, 1'b0, 1'b0);
        send_fields(32'h0000_0031, PIN_DOWN, 1'b0, 1'b0, 1'b0);
        send_fields(32'h0000_0032, PIN_UP,   1'b1, 1'b0, 1'b0);
        send_fields(32'h0000_0064, PIN_UP,   1'b0, 1'b1, 1'b0);

        // Zero debounce samples an edge in the poll that reports it; zero long
        // press time fires long in the poll that debounces the press, except
        // for a press at time zero, which ends as a short press.
        set_timing('0, '0);
        send_fields(32'd5, PIN_DOWN, 1'b1, 1'b0, 1'b1);
        send_fields(32'd6, PIN_UP,   1'b1, 1'b0, 1'b0);
        send_fields(32'd0, PIN_DOWN, 1'b1, 1'b0, 1'b0);
        send_fields(32'd0, PIN_UP,   1'b1, 1'b1, 1'b0);

        // Random phases across the timing range, extremes included. The
        // random settings favor small values so that holds stay short.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_timing('0, '0);
                1: set_timing('1, '1);
                2: set_timing(16'd3, 16'd40);
                3: set_timing(16'd20, 16'd300);
                4: set_timing(CFG_W'($urandom_range(0, 65535)),
                              CFG_W'($urandom_range(0, 65535)));
                5: set_timing(16'd1, '0);
                6: set_timing('0, '1);
                default: set_timing(CFG_W'($urandom_range(0, 60)),
                                    CFG_W'($urandom_range(0, 400)));
            endcase
            run_phase(250);
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (scb.failures == 0 && scb.expected_flags.size() == 0)
            $display("button_debounce_press_classifier_core test passed");
        else
            $display("button_debounce_press_classifier_core test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, with every poll waiting
    // out the longest gap and the longest result stall.
    initial
    begin
        #10000000;
        $display("button_debounce_press_classifier_core test failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bdpc_pkg.sv
hw/rtl/bdpc_update.sv
hw/rtl/button_debounce_press_classifier_core.sv
sim/button_debounce_press_classifier_core_test.sv
